// File: src/lenient_utf8_decoder_top_assert.svh
// Assertion macros shared by the checker of the UTF-8 decoder.
`ifndef LENIENT_UTF8_DECODER_TOP_ASSERT_SVH
`define LENIENT_UTF8_DECODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LUF8_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("luf8 check failed: same-cycle property");

// The consequent must hold in the cycle after the antecedent.
`define LUF8_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("luf8 check failed: next-cycle property");

`endif

// File: src/luf8_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package luf8_pkg;

    // Widths of the item fields.
    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int REPL_W = 7;

    // Reset value of the replacement code ('?').
    localparam logic [REPL_W-1:0] REPL_RESET = 7'd63;

    // Lead and continuation byte prefixes.
    localparam logic [2:0] LEAD2_PREFIX = 3'b110;
    localparam logic [3:0] LEAD3_PREFIX = 4'b1110;
    localparam logic [4:0] LEAD4_PREFIX = 5'b11110;
    localparam logic [1:0] CONT_PREFIX  = 2'b10;

    // Number of continuation bytes that follow each lead.
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;
    localparam logic [1:0] PEND_THREE = 2'd3;

    // One input item.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_text;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            replaced;
        logic            text_done;
    } out_item_t;

    // Sequence state carried from byte to byte.
    typedef struct packed {
        logic [1:0]      bytes_pending;
        logic [CP_W-1:0] partial_value;
        logic            sequence_bad;
    } dec_state_t;

    localparam dec_state_t STATE_CLEAR = '{
        bytes_pending: PEND_NONE,
        partial_value: '0,
        sequence_bad:  1'b0
    };

endpackage

`default_nettype wire

// File: src/luf8_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module luf8_in_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire luf8_pkg::in_item_t in_data,
    input  wire logic              advance,
    output logic                   held_valid,
    output luf8_pkg::in_item_t     held_data
);
    import luf8_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t data_reg;

    // The register takes a new item when empty or when its item moves on.
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

    assign held_valid = valid_reg;
    assign held_data  = data_reg;

endmodule

`default_nettype wire

// File: src/luf8_step.sv
`timescale 1ns / 1ps
`default_nettype none

module luf8_step (
    input  wire luf8_pkg::in_item_t   item,
    input  wire luf8_pkg::dec_state_t state_cur,
    input  wire logic [luf8_pkg::REPL_W-1:0] repl_code,
    output luf8_pkg::dec_state_t      state_next,
    output logic                      emit,
    output luf8_pkg::out_item_t       result
);
    import luf8_pkg::*;

    logic [BYTE_W-1:0] b;
    logic              last;
    logic [CP_W-1:0]   repl_cp;
    logic [CP_W-1:0]   shifted;
    logic [1:0]        pend_dec;
    logic              bad_now;

    assign b        = item.data_byte;
    assign last     = item.end_of_text;
    assign repl_cp  = {{(CP_W-REPL_W){1'b0}}, repl_code};
    assign shifted  = {state_cur.partial_value[CP_W-7:0], b[5:0]};
    assign pend_dec = state_cur.bytes_pending - 2'd1;
    assign bad_now  = state_cur.sequence_bad || (b[7:6] != CONT_PREFIX);

    // One byte of the decode: classify, gather bits, decide on a result.
    always_comb
    begin
        state_next        = state_cur;
        emit              = 1'b0;
        result.code_point = repl_cp;
        result.replaced   = 1'b1;
        result.text_done  = last;

        if (state_cur.bytes_pending == PEND_NONE)
        begin
            // Start of a sequence.
            priority if (!b[7])
            begin
                state_next        = STATE_CLEAR;
                emit              = 1'b1;
                result.code_point = {{(CP_W-BYTE_W){1'b0}}, b};
                result.replaced   = 1'b0;
            end
            else if (b[7:5] == LEAD2_PREFIX)
            begin
                state_next.bytes_pending = PEND_ONE;
                state_next.partial_value = {{(CP_W-5){1'b0}}, b[4:0]};
                state_next.sequence_bad  = 1'b0;
            end
            else if (b[7:4] == LEAD3_PREFIX)
            begin
                state_next.bytes_pending = PEND_TWO;
                state_next.partial_value = {{(CP_W-4){1'b0}}, b[3:0]};
                state_next.sequence_bad  = 1'b0;
            end
            else if (b[7:3] == LEAD4_PREFIX)
            begin
                state_next.bytes_pending = PEND_THREE;
                state_next.partial_value = {{(CP_W-3){1'b0}}, b[2:0]};
                state_next.sequence_bad  = 1'b0;
            end
            else
            begin
                // Stray continuation byte or an invalid lead.
                state_next = STATE_CLEAR;
                emit       = 1'b1;
            end

            // A lead that closes the text is a truncated sequence.
            if (b[7] && (b[6] && !(b[5] && b[4] && b[3])) && last)
            begin
                state_next = STATE_CLEAR;
                emit       = 1'b1;
            end
        end
        else
        begin
            // Continuation slot: the byte is always consumed.
            state_next.bytes_pending = pend_dec;
            state_next.partial_value = shifted;
            state_next.sequence_bad  = bad_now;
            if (pend_dec == PEND_NONE)
            begin
                state_next        = STATE_CLEAR;
                emit              = 1'b1;
                result.code_point = bad_now ? repl_cp : shifted;
                result.replaced   = bad_now;
            end
            else if (last)
            begin
                state_next = STATE_CLEAR;
                emit       = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/lenient_utf8_decoder_top.sv
// A byte waits in the input register; its result is held in the result register.
// Throughput: one byte per cycle unless out_ready stalls; the input register and the
// result register part the two sides, and the sequence state update sets the rate.
// Reset (rst_n, asynchronous, active low) empties both registers, clears the
// sequence state and sets the replacement code to 63.
`timescale 1ns / 1ps
`default_nettype none

module lenient_utf8_decoder_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire luf8_pkg::in_item_t            in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output luf8_pkg::out_item_t                out_data,
    input  wire logic                          cfg_wr_en,
    input  wire logic [luf8_pkg::REPL_W-1:0]   cfg_wr_data
);
    import luf8_pkg::*;

    logic              held_valid;
    in_item_t          held_data;
    logic              advance;
    dec_state_t        state_reg;
    dec_state_t        state_next;
    logic              step_emit;
    out_item_t         step_result;
    logic [REPL_W-1:0] repl_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_data_reg;

    // The held byte is decoded when the result register is free or draining.
    assign advance = held_valid && (!out_valid_reg || out_ready);

    luf8_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .advance    (advance),
        .held_valid (held_valid),
        .held_data  (held_data)
    );

    luf8_step u_step (
        .item       (held_data),
        .state_cur  (state_reg),
        .repl_code  (repl_reg),
        .state_next (state_next),
        .emit       (step_emit),
        .result     (step_result)
    );

    // Sequence state and replacement code.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_CLEAR;
            repl_reg  <= REPL_RESET;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (cfg_wr_en)
            begin
                repl_reg <= cfg_wr_data;
            end
        end
    end

    // Result register valid flag.
    always_comb
    begin
        if (advance)
        begin
            out_valid_next = step_emit;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_emit)
        begin
            out_data_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// File: src/luf8_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "lenient_utf8_decoder_top_assert.svh"

module luf8_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire luf8_pkg::out_item_t out_data
);
    import luf8_pkg::*;

    // A stalled result keeps its value.
    `LUF8_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // With the result register empty, the input side is never stalled.
    `LUF8_ASSERT_SAME(a_in_free, !out_valid, in_ready)

    // A replacement result carries only the seven-bit code.
    `LUF8_ASSERT_SAME(a_repl_narrow, out_valid && out_data.replaced,
                      out_data.code_point[CP_W-1:REPL_W] == '0)

    // A run of idle input with an empty result register flushes the input register,
    // so no result can appear in the cycle after the run.
    `LUF8_ASSERT_NEXT(a_no_invent, (!in_valid && !out_valid) ##1 (!in_valid && !out_valid),
                      !out_valid)

endmodule

bind lenient_utf8_decoder_top luf8_checker u_luf8_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
